/* hdl/actt_pkg.sv */
package actt_pkg;

    // geometry limits of the text buffer
    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 256;
    localparam int ROW_LIM_I = (MAX_ROWS < 128) ? MAX_ROWS : 128;
    localparam int COL_LIM_I = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam logic [7:0] ROW_LIM = 8'(ROW_LIM_I);
    localparam logic [8:0] COL_LIM = 9'(COL_LIM_I);

    // register map
    localparam logic REG_TERM_ROWS = 1'b0;
    localparam logic REG_TERM_COLS = 1'b1;

    localparam logic [7:0] RESET_ROWS = 8'd25;
    localparam logic [8:0] RESET_COLS = 9'd80;

    // stream characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // colour codes
    localparam logic [6:0] SGR_FG_LO  = 7'd30;
    localparam logic [6:0] SGR_FG_HI  = 7'd37;
    localparam logic [6:0] SGR_BG_LO  = 7'd40;
    localparam logic [6:0] SGR_BG_HI  = 7'd47;
    localparam logic [6:0] PARAM_SAT  = 7'd99;
    localparam logic [4:0] FG_DEFAULT = 5'd7;
    localparam logic [4:0] BG_PLAIN   = 5'd0;
    localparam logic [4:0] BG_DEFAULT = 5'd16;

    // result kinds
    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] row;
        logic [7:0] col;
        logic [7:0] cell_char;
        logic [4:0] fg;
        logic [4:0] bg;
        logic [6:0] cursor_row;
        logic [7:0] cursor_col;
    } result_t;

    // all results of one byte; top is the index of the final one
    typedef struct packed {
        logic [1:0]        top;
        result_t [3:0]     res;
    } batch_t;

endpackage

/* hdl/ansi_color_text_terminal.sv */
// path: a byte is registered at acceptance and its results are then
// registered in the output queue; a byte that only parses gives no beat
// throughput: one byte per cycle while each byte gives at most one result
// and out_stall is low; the results of a byte giving several go out one per beat
// reset: cursor at the top left, white on default background, plain text
// mode, 25 rows by 80 columns; no clearing pass
module ansi_color_text_terminal
(
    input  logic       clk,
    input  logic       rst_n,

    // byte stream in
    input  logic [7:0] ch,
    input  logic       in_valid,
    output logic       in_stall,

    // register writes, always taken
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,

    // cell writes and scrolls out
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [6:0] row,
    output logic [7:0] col,
    output logic [7:0] cell_char,
    output logic [4:0] fg,
    output logic [4:0] bg,
    output logic [6:0] cursor_row,
    output logic [7:0] cursor_col,
    output logic       last
);

    // the parser folds one byte into a batch of up to four results in a
    // single pass (a lone escape printed plus the byte after it, each
    // possibly wrapping into a scroll); the queue holds the batch being
    // sent and one spare, so the byte stage keeps moving while a finished
    // beat waits on the output
    logic              push;
    logic              q_full;
    actt_pkg::batch_t  batch;
    actt_pkg::result_t res;

    assign cfg_ready = 1'b1;

    actt_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .batch     (batch)
    );

    actt_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .batch     (batch),
        .q_full    (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .last      (last)
    );

    // result fields onto their own ports
    assign kind       = res.kind;
    assign row        = res.row;
    assign col        = res.col;
    assign cell_char  = res.cell_char;
    assign fg         = res.fg;
    assign bg         = res.bg;
    assign cursor_row = res.cursor_row;
    assign cursor_col = res.cursor_col;

endmodule

/* hdl/actt_parse.sv */
module actt_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           ch,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output actt_pkg::batch_t     batch
);

    typedef enum logic [1:0]
    {
        MODE_TEXT  = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_PARAM = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]                n;
        actt_pkg::result_t [1:0]   res;
        logic [6:0]                row;
        logic [7:0]                col;
    } text_res_t;

    // one printable or control byte against the cursor
    function automatic text_res_t text_step
    (
        input logic [7:0] c,
        input logic [6:0] cur_r,
        input logic [7:0] cur_c,
        input logic [4:0] fg_i,
        input logic [4:0] bg_i,
        input logic [7:0] rows,
        input logic [8:0] cols
    );
        text_res_t  t;
        logic [6:0] r;
        logic [7:0] k;
        logic [6:0] last_r;
        logic [7:0] last_k;
        logic [7:0] wc;
        logic [7:0] wch;
        logic [7:0] nr;
        logic [7:0] nc;
        logic       move;
        last_r = 7'(rows - 8'd1);
        last_k = 8'(cols - 9'd1);
        r = ({1'b0, cur_r} >= rows) ? last_r : cur_r;
        k = ({1'b0, cur_c} >= cols) ? last_k : cur_c;
        t = '0;
        t.row = r;
        t.col = k;
        move = 1'b1;
        wc = k;
        wch = c;
        nr = {1'b0, r};
        nc = k;
        if (c == actt_pkg::CH_NL)
        begin
            wch = actt_pkg::CH_SPACE;
            nr = {1'b0, r} + 8'd1;
            nc = '0;
        end
        else if (c == actt_pkg::CH_BS)
        begin
            if (k == '0)
            begin
                move = 1'b0;
            end
            else
            begin
                wc = k - 8'd1;
                wch = actt_pkg::CH_SPACE;
                nc = k - 8'd1;
            end
        end
        else if (({1'b0, k} + 9'd1) >= cols)
        begin
            nr = {1'b0, r} + 8'd1;
            nc = '0;
        end
        else
        begin
            nc = k + 8'd1;
        end
        if (move)
        begin
            t.res[0].kind = actt_pkg::KIND_CELL;
            t.res[0].row = r;
            t.res[0].col = wc;
            t.res[0].cell_char = wch;
            t.res[0].fg = fg_i;
            t.res[0].bg = bg_i;
            if (nr >= rows)
            begin
                // write keeps the old cursor, the scroll carries the new one
                t.res[0].cursor_row = r;
                t.res[0].cursor_col = k;
                t.res[1].kind = actt_pkg::KIND_SCROLL;
                t.res[1].row = '0;
                t.res[1].col = '0;
                t.res[1].cell_char = actt_pkg::CH_SPACE;
                t.res[1].fg = fg_i;
                t.res[1].bg = bg_i;
                t.res[1].cursor_row = last_r;
                t.res[1].cursor_col = nc;
                t.n = 2'd2;
                t.row = last_r;
                t.col = nc;
            end
            else
            begin
                t.res[0].cursor_row = nr[6:0];
                t.res[0].cursor_col = nc;
                t.n = 2'd1;
                t.row = nr[6:0];
                t.col = nc;
            end
        end
        return t;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [6:0] pv_reg, pv_next;
    logic       pe_reg, pe_next;
    logic [4:0] fg_reg, fg_next;
    logic [4:0] bg_reg, bg_next;
    logic [6:0] cur_row_reg, cur_row_next;
    logic [7:0] cur_col_reg, cur_col_next;
    logic [7:0] rows_reg;
    logic [8:0] cols_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg;

    logic       advance;
    text_res_t  ta, tb;
    logic [6:0] tb_row;
    logic [7:0] tb_col;
    logic       use_a, use_b;
    logic [1:0] na, nb;
    logic [2:0] n_total;
    logic [6:0] p;
    logic [9:0] acc;
    logic [1:0] sel;
    logic [7:0] rows_w;

    assign advance  = byte_valid_reg && !q_full;
    assign in_stall = byte_valid_reg && q_full;

    // input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= ch;
        end
    end

    // geometry registers, held already clamped
    assign rows_w = cfg_data[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= actt_pkg::RESET_ROWS;
            cols_reg <= actt_pkg::RESET_COLS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                actt_pkg::REG_TERM_ROWS:
                begin
                    if (rows_w == '0)
                        rows_reg <= 8'd1;
                    else if (rows_w > actt_pkg::ROW_LIM)
                        rows_reg <= actt_pkg::ROW_LIM;
                    else
                        rows_reg <= rows_w;
                end
                actt_pkg::REG_TERM_COLS:
                begin
                    if (cfg_data == '0)
                        cols_reg <= 9'd1;
                    else if (cfg_data > actt_pkg::COL_LIM)
                        cols_reg <= actt_pkg::COL_LIM;
                    else
                        cols_reg <= cfg_data;
                end
            endcase
        end
    end

    always_comb
    begin
        ta = text_step(actt_pkg::CH_ESC, cur_row_reg, cur_col_reg, fg_reg, bg_reg,
                       rows_reg, cols_reg);
        tb_row = (mode_reg == MODE_ESC) ? ta.row : cur_row_reg;
        tb_col = (mode_reg == MODE_ESC) ? ta.col : cur_col_reg;
        tb = text_step(byte_reg, tb_row, tb_col, fg_reg, bg_reg, rows_reg, cols_reg);

        mode_next = mode_reg;
        pv_next = pv_reg;
        pe_next = pe_reg;
        fg_next = fg_reg;
        bg_next = bg_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        use_a = 1'b0;
        use_b = 1'b0;
        p = pe_reg ? 7'd0 : pv_reg;
        acc = {pv_reg, 3'b000} + {2'b00, pv_reg, 1'b0} + {6'd0, 4'(byte_reg - actt_pkg::CH_ZERO)};

        unique case (mode_reg)
            MODE_ESC:
            begin
                if (byte_reg == actt_pkg::CH_LBR)
                begin
                    mode_next = MODE_PARAM;
                    pv_next = '0;
                    pe_next = 1'b1;
                end
                else
                begin
                    // lone escape is printed, then the byte is taken afresh
                    use_a = 1'b1;
                    if (byte_reg == actt_pkg::CH_ESC)
                    begin
                        mode_next = MODE_ESC;
                        cur_row_next = ta.row;
                        cur_col_next = ta.col;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        use_b = 1'b1;
                        cur_row_next = tb.row;
                        cur_col_next = tb.col;
                    end
                end
            end
            MODE_PARAM:
            begin
                if (byte_reg >= actt_pkg::CH_ZERO && byte_reg <= actt_pkg::CH_NINE)
                begin
                    pv_next = (acc > {3'd0, actt_pkg::PARAM_SAT}) ? actt_pkg::PARAM_SAT
                                                                : acc[6:0];
                    pe_next = 1'b0;
                end
                else if (byte_reg == actt_pkg::CH_SEMI || byte_reg == actt_pkg::CH_M)
                begin
                    if (p == '0)
                    begin
                        fg_next = actt_pkg::FG_DEFAULT;
                        bg_next = actt_pkg::BG_PLAIN;
                    end
                    else if (p >= actt_pkg::SGR_FG_LO && p <= actt_pkg::SGR_FG_HI)
                    begin
                        fg_next = 5'(p - actt_pkg::SGR_FG_LO);
                    end
                    else if (p >= actt_pkg::SGR_BG_LO && p <= actt_pkg::SGR_BG_HI)
                    begin
                        bg_next = 5'(p - actt_pkg::SGR_BG_LO);
                    end
                    pv_next = '0;
                    pe_next = 1'b1;
                    if (byte_reg == actt_pkg::CH_M)
                        mode_next = MODE_TEXT;
                end
                else
                begin
                    // stray byte ends the sequence and is handled as input
                    pv_next = '0;
                    pe_next = 1'b1;
                    if (byte_reg == actt_pkg::CH_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        use_b = 1'b1;
                        cur_row_next = tb.row;
                        cur_col_next = tb.col;
                    end
                end
            end
            default:
            begin
                if (byte_reg == actt_pkg::CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                    use_b = 1'b1;
                    cur_row_next = tb.row;
                    cur_col_next = tb.col;
                end
            end
        endcase

        na = use_a ? ta.n : 2'd0;
        nb = use_b ? tb.n : 2'd0;
        n_total = {1'b0, na} + {1'b0, nb};

        // pack escape results first, then those of the byte itself
        batch.top = 2'(n_total - 3'd1);
        for (int i = 0; i < 4; i++)
        begin
            sel = 2'(i) - na;
            if (2'(i) < na)
                batch.res[i] = ta.res[i[0]];
            else
                batch.res[i] = tb.res[sel[0]];
        end
        push = advance && (n_total != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            pv_reg <= '0;
            pe_reg <= 1'b1;
            fg_reg <= actt_pkg::FG_DEFAULT;
            bg_reg <= actt_pkg::BG_DEFAULT;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            pv_reg <= pv_next;
            pe_reg <= pe_next;
            fg_reg <= fg_next;
            bg_reg <= bg_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

endmodule

/* hdl/actt_outq.sv */
module actt_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  actt_pkg::batch_t     batch,
    output logic                 q_full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output actt_pkg::result_t    res,
    output logic                 last
);

    actt_pkg::batch_t cur_reg;
    actt_pkg::batch_t nxt_reg;
    logic             cur_valid_reg;
    logic             nxt_valid_reg;
    logic [1:0]       ptr_reg;
    logic             beat;
    logic             cur_done;

    assign beat     = cur_valid_reg && !out_stall;
    assign cur_done = beat && (ptr_reg == cur_reg.top);
    assign q_full   = nxt_valid_reg;

    assign out_valid = cur_valid_reg;
    assign res       = cur_reg.res[ptr_reg];
    assign last      = (ptr_reg == cur_reg.top);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            nxt_valid_reg <= 1'b0;
            ptr_reg <= '0;
        end
        else if (cur_done || !cur_valid_reg)
        begin
            ptr_reg <= '0;
            if (nxt_valid_reg)
            begin
                cur_valid_reg <= 1'b1;
                nxt_valid_reg <= 1'b0;
            end
            else
            begin
                cur_valid_reg <= push;
            end
        end
        else
        begin
            if (beat)
                ptr_reg <= ptr_reg + 2'd1;
            if (push)
                nxt_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_done || !cur_valid_reg)
        begin
            if (nxt_valid_reg)
                cur_reg <= nxt_reg;
            else if (push)
                cur_reg <= batch;
        end
        else if (push)
        begin
            nxt_reg <= batch;
        end
    end

    // spare slot is only ever filled behind a busy current slot
    a_nxt_behind_cur: assert property (@(posedge clk) disable iff (!rst_n)
        nxt_valid_reg |-> cur_valid_reg)
        else $error("spare batch held with no current batch");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !nxt_valid_reg)
        else $error("batch pushed into a full queue");

    a_ptr_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (ptr_reg <= cur_reg.top))
        else $error("result pointer beyond batch");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && out_stall) |=> (cur_valid_reg && $stable(ptr_reg)))
        else $error("stalled result moved");

endmodule
